// ----- hdl/bge_pkg.sv -----
// ----------------------------------------------------------------------------
// bge_pkg: shared types and constants for the breakpoint gain envelope
// Point record, item kinds, result codes and the exp2 root table.
// ----------------------------------------------------------------------------
package bge_pkg;

	typedef struct packed {
		logic [31:0] ptime;
		logic [15:0] pgain;
	} point_t;

	typedef logic [31:0] root_tab_t [0:16];

	localparam logic [2:0] KIND_INSERT     = 3'd0;
	localparam logic [2:0] KIND_EVAL       = 3'd1;
	localparam logic [2:0] KIND_COLLAPSE   = 3'd2;
	localparam logic [2:0] KIND_EXPAND     = 3'd3;
	localparam logic [2:0] KIND_SET_LENGTH = 3'd4;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_OUTSIDE = 2'd2;

	localparam logic [15:0] UNITY    = 16'h8000;
	localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;
	localparam logic [31:0] ONE_Q30  = 32'h4000_0000;

	// Chain of Q2.30 roots 2^(2^-i), each the truncated square root of the last
	function automatic root_tab_t root_table();
		root_tab_t   tab;
		logic [63:0] c;
		logic [63:0] v;
		logic [63:0] res;
		logic [63:0] bit_q;
		c = 64'd1 << 31;
		tab[0] = c[31:0];
		for (int i = 1; i <= 16; i++) begin
			v = c << 30;
			res = '0;
			bit_q = 64'd1 << 62;
			for (int j = 0; j < 32; j++) begin
				if (v >= res + bit_q) begin
					v = v - (res + bit_q);
					res = (res >> 1) + bit_q;
				end else begin
					res = res >> 1;
				end
				bit_q = bit_q >> 2;
			end
			c = res;
			tab[i] = c[31:0];
		end
		return tab;
	endfunction

	localparam root_tab_t ROOT_Q30 = root_table();

	function automatic logic [3:0] msb16(logic [15:0] g);
		logic [3:0] p;
		p = '0;
		for (int i = 0; i < 16; i++) begin
			if (g[i]) p = 4'(i);
		end
		return p;
	endfunction

endpackage

// ----- hdl/bge_mem.sv -----
// ----------------------------------------------------------------------------
// bge_mem: breakpoint table storage
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bge_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  bge_pkg::point_t wpoint,
	input  logic [AW-1:0]   raddr,
	output bge_pkg::point_t rpoint
);
	import bge_pkg::*;

	point_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wpoint;
	end

	always_ff @(posedge clk) begin
		rpoint <= mem_q[raddr];
	end

endmodule

// ----- hdl/bge_mul.sv -----
// ----------------------------------------------------------------------------
// bge_mul: shared 32 x 32 unsigned multiplier
// Used for log squaring, interpolation products and exp root products.
// ----------------------------------------------------------------------------
module bge_mul (
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [63:0] p
);
	import bge_pkg::*;

	assign p = {32'b0, a} * {32'b0, b};

endmodule

// ----- hdl/breakpoint_gain_envelope_unit.sv -----
// ----------------------------------------------------------------------------
// breakpoint_gain_envelope_unit: gain envelope over a sorted breakpoint table
// Insert, evaluate, collapse, expand and set-length items on a point table.
//
// channel  dir  tdata                                   tuser
// s_axis   in   time_a[31:0] time_b[63:32] gain_in[79:64] kind[2:0]
// m_axis   out  gain_out[15:0] point_index[21:16] status[23:22]  -
// cfg      in   time_offset (cfg_wdata), written when cfg_we
//
// One item at a time; one shared multiplier and one table read port.
// Insert, collapse, expand, set length: walk the table entry by entry.
// Evaluate: binary search, 2 x 16 log squarings, 20 divide steps, 16 exp
// root products. Reset then writes the two initial points. A waiting result
// in the output register holds off intake only once the next result is ready.
// ----------------------------------------------------------------------------
module breakpoint_gain_envelope_unit #(
	parameter int MAX_POINTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [79:0] s_axis_tdata,  // time_a, time_b, gain_in
	input  logic [2:0]  s_axis_tuser,  // kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata   // gain_out, point_index, status
);
	import bge_pkg::*;

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = $clog2(MAX_POINTS + 1);

	typedef enum logic [4:0] {
		S_INIT0, S_INIT1, S_IDLE, S_RD, S_INS_U, S_SH_U, S_INS_WR, S_CMP_U,
		S_EXP_U, S_EV0_U, S_EV1_U, S_SR_CHK, S_SR_U, S_LO_U, S_HI_U,
		S_LOG_INIT, S_LOG, S_LOG_END, S_INT0, S_INT1, S_DIV, S_EXP_INIT,
		S_EXPS, S_FIN, S_DONE
	} state_t;

	state_t             state_q, ret_q;
	logic signed [31:0] offset_q;
	logic [2:0]         kind_q;
	logic [31:0]        ta_q, tb_q;
	logic [15:0]        gin_q;
	logic signed [33:0] te_q, r1_q;
	logic [CW-1:0]      count_q, ptr_q, wr_q, pos_q, lo_q, hi_q;
	logic [31:0]        tlo_q, dt_q, to_q;
	logic [15:0]        glo_q, ghi_q;
	logic               side_q;
	logic [3:0]         p_q;
	logic [31:0]        x_q;
	logic [15:0]        r_q;
	logic [4:0]         step_q;
	logic [19:0]        mag_a_q, mag_b_q;
	logic [51:0]        acc_q;
	logic [31:0]        rem_q;
	logic [19:0]        nlo_q;
	logic [31:0]        y_q;
	logic [15:0]        fr_q;
	logic [4:0]         s_q;
	logic [15:0]        res_gain_q;
	logic [5:0]         res_idx_q;
	logic [1:0]         res_st_q;
	logic [15:0]        out_gain_q;
	logic [5:0]         out_idx_q;
	logic [1:0]         out_st_q;
	logic               m_valid_q;

	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	point_t             mem_wpt;
	point_t             rpt;
	logic [31:0]        mul_a, mul_b;
	logic [63:0]        mul_p;

	logic [31:0]        in_ta, in_tb;
	logic [15:0]        in_gin;
	logic signed [33:0] in_te, in_r1, off_ext;
	logic [31:0]        rt;
	logic signed [33:0] rt_s, d34;
	logic signed [34:0] cl_diff;
	logic [31:0]        cl_t, col_t, len_t, new_t, ex_t;
	logic [32:0]        ex_sum;
	logic               last, col_keep, len_keep, keep;
	logic [CW-1:0]      mid;
	logic [15:0]        lg_g;
	logic [3:0]         lg_p;
	logic [31:0]        lg_x, sq;
	logic [19:0]        lg_mag;
	logic [51:0]        num_sum;
	logic [32:0]        div_cat;
	logic               div_ge;
	logic [31:0]        div_rem;
	logic [47:0]        fin_sum, fin_sh;
	logic [15:0]        fin_gain;

	bge_mem #(.DEPTH(MAX_POINTS), .AW(AW)) u_mem (
		.clk    (clk),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wpoint (mem_wpt),
		.raddr  (ptr_q[AW-1:0]),
		.rpoint (rpt)
	);

	bge_mul u_mul (.a(mul_a), .b(mul_b), .p(mul_p));

	assign in_ta   = s_axis_tdata[31:0];
	assign in_tb   = s_axis_tdata[63:32];
	assign in_gin  = (s_axis_tdata[79:64] > UNITY) ? UNITY : s_axis_tdata[79:64];
	assign off_ext = $signed({{2{offset_q[31]}}, offset_q});
	assign in_te   = $signed({2'b00, in_ta}) - off_ext;
	assign in_r1   = $signed({2'b00, in_tb}) - off_ext;

	assign rt      = rpt.ptime;
	assign rt_s    = $signed({2'b00, rt});
	assign last    = (ptr_q == count_q - CW'(1));
	assign d34     = r1_q - te_q;
	assign cl_diff = $signed({3'b000, rt}) - $signed({d34[33], d34});
	assign ex_sum  = {1'b0, rt} + {1'b0, tb_q};
	assign mid     = CW'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);

	always_comb begin
		if (cl_diff < 0) cl_t = '0;
		else if (cl_diff > $signed({3'b000, TIME_MAX})) cl_t = TIME_MAX;
		else cl_t = cl_diff[31:0];
		col_keep = (ptr_q == '0) || last || !(rt_s >= te_q && rt_s < r1_q);
		col_t    = (rt_s >= r1_q) ? cl_t : rt;
		len_keep = last || (rt <= ta_q);
		len_t    = last ? ta_q : rt;
		keep     = (kind_q == KIND_COLLAPSE) ? col_keep : len_keep;
		new_t    = (kind_q == KIND_COLLAPSE) ? col_t : len_t;
		ex_t     = (rt_s > te_q) ? (ex_sum[32] ? TIME_MAX : ex_sum[31:0]) : rt;
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wpt   = '0;
		unique case (state_q)
			S_INIT0: begin
				mem_we  = 1'b1;
				mem_wpt = '{ptime: 32'd0, pgain: UNITY};
			end
			S_INIT1: begin
				mem_we    = 1'b1;
				mem_waddr = AW'(1);
				mem_wpt   = '{ptime: TIME_MAX, pgain: UNITY};
			end
			S_SH_U: begin
				mem_we    = 1'b1;
				mem_waddr = AW'(ptr_q + CW'(1));
				mem_wpt   = rpt;
			end
			S_INS_WR: begin
				mem_we    = 1'b1;
				mem_waddr = pos_q[AW-1:0];
				mem_wpt   = '{ptime: ta_q, pgain: gin_q};
			end
			S_CMP_U: begin
				mem_we    = keep;
				mem_waddr = wr_q[AW-1:0];
				mem_wpt   = '{ptime: new_t, pgain: rpt.pgain};
			end
			S_EXP_U: begin
				mem_we    = 1'b1;
				mem_waddr = ptr_q[AW-1:0];
				mem_wpt   = '{ptime: ex_t, pgain: rpt.pgain};
			end
			default: ;
		endcase
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_LOG: begin
				mul_a = x_q;
				mul_b = x_q;
			end
			S_INT0: begin
				mul_a = {12'b0, mag_a_q};
				mul_b = dt_q - to_q;
			end
			S_INT1: begin
				mul_a = {12'b0, mag_b_q};
				mul_b = to_q;
			end
			S_EXPS: begin
				mul_a = y_q;
				mul_b = ROOT_Q30[step_q];
			end
			default: ;
		endcase
	end

	always_comb begin
		lg_g     = side_q ? ghi_q : glo_q;
		lg_p     = msb16(lg_g);
		lg_x     = (lg_g == '0) ? ONE_Q30 : ({16'b0, lg_g} << (5'd30 - {1'b0, lg_p}));
		sq       = mul_p[61:30];
		lg_mag   = {4'd15 - p_q, 16'b0} - {4'b0, r_q};
		num_sum  = acc_q + mul_p[51:0];
		div_cat  = {rem_q, nlo_q[19]};
		div_ge   = div_cat >= {1'b0, dt_q};
		div_rem  = div_ge ? 32'(div_cat - {1'b0, dt_q}) : div_cat[31:0];
		fin_sum  = {1'b0, y_q, 15'b0} + (48'd1 << (6'd29 + {1'b0, s_q}));
		fin_sh   = fin_sum >> (6'd30 + {1'b0, s_q});
		fin_gain = (fin_sh > {32'b0, UNITY}) ? UNITY : fin_sh[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_INIT0;
			count_q   <= CW'(2);
			offset_q  <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_we) offset_q <= cfg_wdata;
			if (m_valid_q && m_axis_tready && state_q != S_DONE) m_valid_q <= 1'b0;
			unique case (state_q)
				S_INIT0: state_q <= S_INIT1;
				S_INIT1: state_q <= S_IDLE;
				S_IDLE: begin
					if (s_axis_tvalid) begin
						kind_q     <= s_axis_tuser;
						ta_q       <= in_ta;
						tb_q       <= in_tb;
						gin_q      <= in_gin;
						te_q       <= in_te;
						r1_q       <= in_r1;
						res_gain_q <= UNITY;
						res_idx_q  <= '0;
						res_st_q   <= ST_OK;
						ptr_q      <= '0;
						wr_q       <= '0;
						case (s_axis_tuser)
							KIND_INSERT: begin
								if (count_q >= CW'(MAX_POINTS)) begin
									res_st_q <= ST_FULL;
									state_q  <= S_DONE;
								end else begin
									ret_q   <= S_INS_U;
									state_q <= S_RD;
								end
							end
							KIND_EVAL: begin
								ret_q   <= S_EV0_U;
								state_q <= S_RD;
							end
							KIND_COLLAPSE, KIND_SET_LENGTH: begin
								ret_q   <= S_CMP_U;
								state_q <= S_RD;
							end
							KIND_EXPAND: begin
								ret_q   <= S_EXP_U;
								state_q <= S_RD;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_RD: state_q <= ret_q;
				S_INS_U: begin
					if (ptr_q < count_q && ta_q > rt) begin
						ptr_q   <= ptr_q + CW'(1);
						ret_q   <= S_INS_U;
						state_q <= S_RD;
					end else begin
						pos_q <= ptr_q;
						if (ptr_q == count_q) begin
							state_q <= S_INS_WR;
						end else begin
							ptr_q   <= count_q - CW'(1);
							ret_q   <= S_SH_U;
							state_q <= S_RD;
						end
					end
				end
				S_SH_U: begin
					if (ptr_q == pos_q) begin
						state_q <= S_INS_WR;
					end else begin
						ptr_q   <= ptr_q - CW'(1);
						ret_q   <= S_SH_U;
						state_q <= S_RD;
					end
				end
				S_INS_WR: begin
					count_q   <= count_q + CW'(1);
					res_idx_q <= 6'(pos_q);
					state_q   <= S_DONE;
				end
				S_CMP_U: begin
					if (keep) wr_q <= wr_q + CW'(1);
					if (last) begin
						count_q <= wr_q + CW'(1);
						state_q <= S_DONE;
					end else begin
						ptr_q   <= ptr_q + CW'(1);
						ret_q   <= S_CMP_U;
						state_q <= S_RD;
					end
				end
				S_EXP_U: begin
					if (last) begin
						state_q <= S_DONE;
					end else begin
						ptr_q   <= ptr_q + CW'(1);
						ret_q   <= S_EXP_U;
						state_q <= S_RD;
					end
				end
				S_EV0_U: begin
					if (te_q < rt_s) begin
						res_st_q <= ST_OUTSIDE;
						state_q  <= S_DONE;
					end else begin
						ptr_q   <= count_q - CW'(1);
						ret_q   <= S_EV1_U;
						state_q <= S_RD;
					end
				end
				S_EV1_U: begin
					if (te_q > rt_s) begin
						res_st_q <= ST_OUTSIDE;
						state_q  <= S_DONE;
					end else begin
						lo_q    <= '0;
						hi_q    <= ptr_q;
						state_q <= S_SR_CHK;
					end
				end
				S_SR_CHK: begin
					if ({1'b0, hi_q} > {1'b0, lo_q} + (CW+1)'(1)) begin
						ptr_q <= mid;
						ret_q <= S_SR_U;
					end else begin
						ptr_q <= lo_q;
						ret_q <= S_LO_U;
					end
					state_q <= S_RD;
				end
				S_SR_U: begin
					if (te_q < rt_s) hi_q <= ptr_q;
					else lo_q <= ptr_q;
					state_q <= S_SR_CHK;
				end
				S_LO_U: begin
					tlo_q   <= rt;
					glo_q   <= rpt.pgain;
					ptr_q   <= hi_q;
					ret_q   <= S_HI_U;
					state_q <= S_RD;
				end
				S_HI_U: begin
					ghi_q <= rpt.pgain;
					if (rt > tlo_q) begin
						dt_q    <= rt - tlo_q;
						to_q    <= te_q[31:0] - tlo_q;
						side_q  <= 1'b0;
						state_q <= S_LOG_INIT;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_LOG_INIT: begin
					p_q     <= lg_p;
					x_q     <= lg_x;
					r_q     <= '0;
					step_q  <= '0;
					state_q <= S_LOG;
				end
				S_LOG: begin
					x_q    <= sq[31] ? (sq >> 1) : sq;
					r_q    <= {r_q[14:0], sq[31]};
					step_q <= step_q + 5'd1;
					if (step_q == 5'd15) state_q <= S_LOG_END;
				end
				S_LOG_END: begin
					if (!side_q) begin
						mag_a_q <= lg_mag;
						side_q  <= 1'b1;
						state_q <= S_LOG_INIT;
					end else begin
						mag_b_q <= lg_mag;
						state_q <= S_INT0;
					end
				end
				S_INT0: begin
					acc_q   <= mul_p[51:0];
					state_q <= S_INT1;
				end
				S_INT1: begin
					rem_q   <= num_sum[51:20];
					nlo_q   <= num_sum[19:0];
					step_q  <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					rem_q  <= div_rem;
					nlo_q  <= {nlo_q[18:0], div_ge};
					step_q <= step_q + 5'd1;
					if (step_q == 5'd19) state_q <= S_EXP_INIT;
				end
				S_EXP_INIT: begin
					y_q <= ONE_Q30;
					if (nlo_q[15:0] == '0) begin
						s_q     <= {1'b0, nlo_q[19:16]};
						state_q <= S_FIN;
					end else begin
						fr_q    <= 16'(17'h10000 - {1'b0, nlo_q[15:0]});
						s_q     <= {1'b0, nlo_q[19:16]} + 5'd1;
						step_q  <= 5'd1;
						state_q <= S_EXPS;
					end
				end
				S_EXPS: begin
					if (fr_q[15]) y_q <= mul_p[61:30];
					fr_q   <= {fr_q[14:0], 1'b0};
					step_q <= step_q + 5'd1;
					if (step_q == 5'd16) state_q <= S_FIN;
				end
				S_FIN: begin
					res_gain_q <= fin_gain;
					state_q    <= S_DONE;
				end
				S_DONE: begin
					if (!m_valid_q || m_axis_tready) begin
						out_gain_q <= res_gain_q;
						out_idx_q  <= res_idx_q;
						out_st_q   <= res_st_q;
						m_valid_q  <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {out_st_q, out_idx_q, out_gain_q};

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= CW'(1) && count_q <= CW'(MAX_POINTS))
		else $error("point count out of range");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && res_st_q == ST_FULL) |-> count_q == CW'(MAX_POINTS))
		else $error("insert dropped with room left");

	a_search_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SR_CHK) |-> lo_q <= hi_q)
		else $error("search bounds crossed");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> rem_q < dt_q)
		else $error("divider remainder not below divisor");

endmodule
